>>> hw/rtl/frie_pkg.sv
// Shared types, constants and codes for the four-register instruction executor.
package frie_pkg;

   localparam int NumRegistersDefault = 4;
   localparam int MemoryBytesDefault  = 4096;
   localparam int ReturnDepthDefault  = 16;

   localparam int PcWidth   = 13;
   localparam int WordWidth = 64;

   localparam logic [15:0] OpExit   = 16'h00E0;
   localparam logic [15:0] OpReturn = 16'h00EE;
   localparam logic [15:0] OpDebug  = 16'hFFF0;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_PRINT    = 3'd1,
      ST_EXIT     = 3'd2,
      ST_DEBUG    = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_UNIMPL   = 3'd5,
      ST_BOUND    = 3'd6,
      ST_OVERFLOW = 3'd7
   } status_type;

   // ALU operation selected by the low digit of group 8
   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_OR  = 3'd1,
      ALU_AND = 3'd2,
      ALU_XOR = 3'd3,
      ALU_SUB = 3'd4,
      ALU_MUL = 3'd5,
      ALU_DIV = 3'd6
   } alu_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_LONG = 2'd2,
      FSM_DONE = 2'd3
   } fsm_state_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic [63:0] operand_bytes;
      logic [6:0]  random_draw;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] next_pc;
      logic [1:0]  print_format;
      logic [63:0] value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch the accepted item
      logic execute;    // decode and commit a short instruction
      logic long_start; // launch multiply or divide
      logic long_commit;// commit the long result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_long;
      logic long_done;
   } dp_status_type;

endpackage

>>> hw/rtl/frie_muldiv.sv
// Iterative 64-bit multiplier and restoring divider, one bit a cycle.
module frie_muldiv
   import frie_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 is_div,
   input  logic [WordWidth-1:0] op_a,
   input  logic [WordWidth-1:0] op_b,
   output logic                 done,
   output logic [WordWidth-1:0] result
);

   logic                 busy_ff, busy_in;
   logic [6:0]           count_ff, count_in;
   logic                 div_ff, div_in;
   logic [WordWidth-1:0] acc_ff, acc_in;   // product or remainder
   logic [WordWidth-1:0] quo_ff, quo_in;   // multiplier shift or quotient
   logic [WordWidth-1:0] dsr_ff, dsr_in;   // multiplicand shift or divisor
   logic                 done_ff, done_in;
   logic [WordWidth:0]   trial;
   logic [WordWidth:0]   rem_shift;

   // load on start, else one step of shift-add or shift-subtract
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      done_in  = 1'b0;
      rem_shift = {acc_ff, quo_ff[WordWidth-1]};
      trial     = rem_shift - {1'b0, dsr_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = 7'd0;
         div_in   = is_div;
         acc_in   = '0;
         quo_in   = is_div ? op_a : op_b;
         dsr_in   = is_div ? op_b : op_a;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!trial[WordWidth]) begin
               acc_in = trial[WordWidth-1:0];
               quo_in = {quo_ff[WordWidth-2:0], 1'b1};
            end else begin
               acc_in = rem_shift[WordWidth-1:0];
               quo_in = {quo_ff[WordWidth-2:0], 1'b0};
            end
         end else begin
            if (quo_ff[0]) begin
               acc_in = acc_ff + dsr_ff;
            end
            quo_in = {1'b0, quo_ff[WordWidth-1:1]};
            dsr_in = {dsr_ff[WordWidth-2:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'(WordWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      div_ff <= div_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done   = done_ff;
   // an all-zero divisor leaves all ones in the quotient naturally
   assign result = div_ff ? quo_ff : acc_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("start did not make unit busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff < 7'(WordWidth))
      else $error("step count overran");

endmodule

>>> hw/rtl/frie_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
module frie_ctrl
   import frie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type stat
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_blocked;
   logic          accept;

   // hold the input while a result waits and is not taken this cycle
   assign rsp_blocked = rsp_valid_ff && rsp_stall;
   assign accept      = (state_ff == FSM_IDLE) && req_valid && !rsp_blocked;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_EXEC;
         FSM_EXEC: state_in = stat.is_long ? FSM_LONG : FSM_DONE;
         FSM_LONG: if (stat.long_done) state_in = FSM_DONE;
         FSM_DONE: if (!rsp_valid_ff || !rsp_stall) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd             = '0;
      req_stall       = 1'b1;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         FSM_IDLE: begin
            req_stall   = rsp_blocked;
            cmd.capture = accept;
         end
         FSM_EXEC: begin
            cmd.execute    = !stat.is_long;
            cmd.long_start = stat.is_long;
         end
         FSM_LONG: cmd.long_commit = stat.long_done;
         FSM_DONE: if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == FSM_EXEC)
      else $error("accepted item not executed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.long_start, cmd.long_commit}))
      else $error("conflicting datapath commands");

endmodule

>>> hw/rtl/frie_datapath.sv
// Datapath: register file, pc, return stack, decode and result register.
module frie_datapath
   import frie_pkg::*;
#(
   parameter int NUM_REGISTERS = NumRegistersDefault,
   parameter int MEMORY_BYTES  = MemoryBytesDefault,
   parameter int RETURN_DEPTH  = ReturnDepthDefault
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          rsp_take,
   output rsp_type       rsp_data,
   input  dp_cmd_type    cmd,
   output dp_status_type stat
);

   localparam int DepthWidth = $clog2(RETURN_DEPTH + 1);
   localparam int StackIdx   = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
   localparam int RegIdx     = $clog2(NUM_REGISTERS);

   logic [WordWidth-1:0]  regs_ff [NUM_REGISTERS];
   logic [PcWidth-1:0]    pc_ff;
   logic [PcWidth-1:0]    stack_ff [RETURN_DEPTH];
   logic [DepthWidth-1:0] depth_ff;
   req_type               item_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [15:0] op;
   logic [3:0]  da, db, dc;
   logic [WordWidth-1:0] rb, rc, ra;
   logic        cond;
   logic        wr_en;
   logic [RegIdx-1:0] wr_idx;
   logic [WordWidth-1:0] wr_val;
   logic        push, pop;
   logic [PcWidth-1:0] npc;
   logic [StackIdx-1:0] top_idx, push_idx;
   logic        is_long;
   logic        md_done;
   logic [WordWidth-1:0] md_result;
   logic [WordWidth-1:0] alu_val;

   assign op = item_ff.opcode;
   assign da = op[11:8];
   assign db = op[7:4];
   assign dc = op[3:0];
   assign ra = regs_ff[da[RegIdx-1:0]];
   assign rb = regs_ff[db[RegIdx-1:0]];
   assign rc = regs_ff[dc[RegIdx-1:0]];
   assign push_idx = depth_ff[StackIdx-1:0];
   assign top_idx  = StackIdx'(depth_ff - DepthWidth'(1));

   assign is_long = (op[15:12] == 4'h8) && (da < 4'd4) && (db < 4'd4)
                    && (dc == 4'(ALU_MUL) || dc == 4'(ALU_DIV))
                    && ({19'd0, pc_ff} + 32'd1 < 32'(MEMORY_BYTES));
   assign stat.is_long   = is_long;
   assign stat.long_done = md_done;

   frie_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.long_start),
      .is_div (dc == 4'(ALU_DIV)),
      .op_a   (ra),
      .op_b   (rb),
      .done   (md_done),
      .result (md_result)
   );

   // short ALU ops
   always_comb begin
      case (dc[2:0])
         ALU_ADD: alu_val = ra + rb;
         ALU_OR:  alu_val = ra | rb;
         ALU_AND: alu_val = ra & rb;
         ALU_XOR: alu_val = ra ^ rb;
         ALU_SUB: alu_val = ra - rb;
         default: alu_val = md_result;
      endcase
   end

   // decode one instruction
   always_comb begin
      rsp_in = '0;
      rsp_in.status  = ST_RUN;
      npc    = pc_ff;
      wr_en  = 1'b0;
      wr_idx = da[RegIdx-1:0];
      wr_val = alu_val;
      push   = 1'b0;
      pop    = 1'b0;
      cond   = 1'b0;
      if ({19'd0, pc_ff} + 32'd1 >= 32'(MEMORY_BYTES)) begin
         rsp_in.status = ST_BOUND;
      end else begin
         case (op[15:12])
            4'h0: begin
               if (op == OpExit) begin
                  rsp_in.status = ST_EXIT;
               end else if (op == OpReturn) begin
                  if (depth_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     pop = 1'b1;
                     npc = stack_ff[top_idx];
                  end
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'h1: npc = {1'b0, op[11:0]};
            4'h2, 4'h9: begin
               if (da >= 4'd1 && da <= 4'd3 && db < 4'd4 && dc < 4'd4) begin
                  cond = (da == 4'd1) ? (rb == rc) :
                         (da == 4'd2) ? (rb != rc) : (rb > rc);
               end else if (op[15:12] == 4'h2 && da == 4'd4 && db == 4'd0
                            && dc < 4'd4) begin
                  cond = (rc == '0);
               end else if (op[15:12] == 4'h9 && da == 4'd0 && db < 4'd4
                            && dc < 4'd2) begin
                  cond = dc[0] ? (rb != '0) : (rb == '0);
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
               if (rsp_in.status == ST_RUN) begin
                  if (op[15:12] == 4'h2) begin
                     npc = cond ? {5'd0, item_ff.operand_bytes[63:56]}
                                : pc_ff + PcWidth'(3);
                  end else begin
                     npc = pc_ff + (cond ? PcWidth'(4) : PcWidth'(2));
                  end
               end
            end
            4'h3: begin
               if (da == 4'd0 && db < 4'd3 && dc < 4'd4) begin
                  rsp_in.status       = ST_PRINT;
                  rsp_in.print_format = db[1:0];
                  rsp_in.value        = rc;
                  npc = pc_ff + PcWidth'(2);
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'h4: begin
               if (depth_ff >= DepthWidth'(RETURN_DEPTH)) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  push = 1'b1;
                  npc  = {1'b0, op[11:0]};
               end
            end
            4'h5: begin
               if (da < 4'd4 && db == 4'd0 && dc < 4'd4) begin
                  wr_en = 1'b1;
                  case (dc[1:0])
                     2'd0: begin
                        wr_val = {56'd0, item_ff.operand_bytes[63:56]};
                        npc = pc_ff + PcWidth'(3);
                     end
                     2'd1: begin
                        wr_val = {48'd0, item_ff.operand_bytes[63:48]};
                        npc = pc_ff + PcWidth'(4);
                     end
                     2'd2: begin
                        wr_val = {32'd0, item_ff.operand_bytes[63:32]};
                        npc = pc_ff + PcWidth'(6);
                     end
                     default: begin
                        wr_val = item_ff.operand_bytes;
                        npc = pc_ff + PcWidth'(10);
                     end
                  endcase
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'h7: begin
               if (da < 4'd4 && op[7:0] == 8'd0) begin
                  wr_en  = 1'b1;
                  wr_val = {57'd0, item_ff.random_draw} + 64'd1;
                  npc = pc_ff + PcWidth'(2);
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'h8: begin
               if (da < 4'd4 && db < 4'd4 && dc <= 4'd6) begin
                  wr_en = 1'b1;
                  npc = pc_ff + PcWidth'(2);
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'hA: begin
               if (da < 4'd4 && db < 4'd4 && dc == 4'd0) begin
                  wr_en  = 1'b1;
                  wr_val = rb;
                  npc = pc_ff + PcWidth'(2);
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            4'hF: begin
               if (op[15:4] == OpDebug[15:4] && dc < 4'd4) begin
                  rsp_in.status = ST_DEBUG;
                  rsp_in.value  = rc;
               end else begin
                  rsp_in.status = ST_UNIMPL;
               end
            end
            default: rsp_in.status = ST_UNIMPL;
         endcase
      end
      rsp_in.next_pc = npc;
   end

   // capture, commit and result hold
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         depth_ff <= '0;
         for (int i = 0; i < NUM_REGISTERS; i++) regs_ff[i] <= '0;
      end else if (cmd.execute || cmd.long_commit) begin
         pc_ff <= npc;
         if (wr_en) regs_ff[wr_idx] <= wr_val;
         if (push) depth_ff <= depth_ff + DepthWidth'(1);
         if (pop)  depth_ff <= depth_ff - DepthWidth'(1);
      end
      if (cmd.execute && push) stack_ff[push_idx] <= pc_ff + PcWidth'(2);
      if (cmd.capture) item_ff <= req_data;
      if (cmd.execute || cmd.long_commit) rsp_ff <= rsp_in;
      else if (rsp_take) rsp_ff <= rsp_ff;
   end

   assign rsp_data = rsp_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthWidth'(RETURN_DEPTH))
      else $error("return depth overran");
   a_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("push and pop together");
   a_long_write: assert property (@(posedge clock) disable iff (reset)
      cmd.long_commit |-> wr_en)
      else $error("long op without register write");

endmodule

>>> hw/rtl/four_register_instruction_executor.sv
// Top level of the four-register 64-bit instruction executor.
// An accepted item passes through the execute and done states before its result is
// offered; multiply and divide also pass a long state on the one-bit-a-cycle unit.
// A new item is accepted only once the previous one has left the done state.
// Reset (synchronous): registers, pc and return depth cleared; the return
// stack entries are undefined until pushed.
module four_register_instruction_executor
   import frie_pkg::*;
#(
   parameter int NUM_REGISTERS = NumRegistersDefault,
   parameter int MEMORY_BYTES  = MemoryBytesDefault,
   parameter int RETURN_DEPTH  = ReturnDepthDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   frie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   frie_datapath #(
      .NUM_REGISTERS (NUM_REGISTERS),
      .MEMORY_BYTES  (MEMORY_BYTES),
      .RETURN_DEPTH  (RETURN_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_take (rsp_valid && !rsp_stall),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
